### design/tpco_pkg.sv
// Shared types for the triangle plane nearest-point pipeline.
// No dependencies.
package tpco_pkg;

    typedef struct packed {
        logic adv;
        logic vld;
    } t_ctl;

endpackage

### design/tpco_if.sv
// Input and result channel interfaces: valid, ready and payload.
// Width follows COORD_BITS of the instantiating level.
interface tpco_in_if #(parameter int COORD_BITS = 16) ();
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] a_x, a_y, a_z;
    logic signed [COORD_BITS-1:0] b_x, b_y, b_z;
    logic signed [COORD_BITS-1:0] c_x, c_y, c_z;
    logic signed [COORD_BITS-1:0] query_x, query_y, query_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    query_x, query_y, query_z, input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  query_x, query_y, query_z, output ready);
endinterface

interface tpco_out_if #(parameter int COORD_BITS = 16) ();
    logic valid;
    logic ready;
    logic valid_res;
    logic signed [COORD_BITS-1:0] near_x, near_y, near_z;
    logic [31:0] dist_sq;
    logic inside_res;
    logic visible;

    modport source (output valid, valid_res, near_x, near_y, near_z, dist_sq,
                    inside_res, visible, input ready);
    modport sink (input valid, valid_res, near_x, near_y, near_z, dist_sq,
                  inside_res, visible, output ready);
endinterface

### design/tpco_div.sv
// Pipelined restoring divider: one quotient bit per stage plus an overflow stage.
// Depends on tpco_pkg for the stage control struct.
module tpco_div import tpco_pkg::*; #(
    parameter int NW   = 89,
    parameter int DENW = 70,
    parameter int QB   = 17
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ctl            i_ctl,
    input  logic [NW-1:0]   i_mag,
    input  logic [DENW-1:0] i_den,
    input  logic            i_neg,
    output logic            o_vld,
    output logic [QB-1:0]   o_quo,
    output logic            o_ovf,
    output logic            o_neg
);
    localparam int RW = NW + 1;

    logic [RW-1:0]   r_rem [QB+1];
    logic [DENW-1:0] r_den [QB+1];
    logic [QB-1:0]   r_quo [QB+1];
    logic            r_ovf [QB+1];
    logic            r_neg [QB+1];
    logic            r_vld [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld[0] <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_rem[0] <= RW'(i_mag);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= RW'(i_mag) >= (RW'(i_den) << QB);
            r_neg[0] <= i_neg;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        logic [RW-1:0] n_shd;
        logic          n_ge;

        always_comb begin
            n_shd = RW'(r_den[j-1]) << (QB - j);
            n_ge  = r_rem[j-1] >= n_shd;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_ctl.adv) begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_rem[j] <= n_ge ? (r_rem[j-1] - n_shd) : r_rem[j-1];
                r_den[j] <= r_den[j-1];
                r_quo[j] <= r_quo[j-1] | (QB'(n_ge) << (QB - j));
                r_ovf[j] <= r_ovf[j-1];
                r_neg[j] <= r_neg[j-1];
            end
        end
    end

    assign o_vld = r_vld[QB];
    assign o_quo = r_quo[QB];
    assign o_ovf = r_ovf[QB];
    assign o_neg = r_neg[QB];

endmodule

### design/triangle_plane_closest_to_origin.sv
// Throughput: one item per cycle while the result is not stalled; the quotient divider retires one bit per stage.
// A stall at the result holds every stage; nothing is dropped or repeated.
// Reset clears all valid bits; payload registers are not reset.
// Depends on tpco_pkg, tpco_if and tpco_div.
module triangle_plane_closest_to_origin import tpco_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpco_in_if.sink     i_in,
    tpco_out_if.source  o_out
);
    localparam int W   = COORD_BITS;
    localparam int VW  = W + 1;
    localparam int DW  = 2 * W + 3;
    localparam int LW  = 2 * DW + 1;
    localparam int PW  = LW + VW;
    localparam int NW  = PW + 1;
    localparam int QB  = W + 1;
    localparam int SW  = 2 * W;
    localparam int XW  = (SW > 33) ? SW : 33;
    localparam int VSW = 2 * W + 3;
    localparam int SDW = 6 * W + 2;
    localparam logic signed [W+2:0] HI3 = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] LO3 = {4'b1111, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] HIW = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] LOW = {1'b1, {(W-1){1'b0}}};

    logic adv;
    logic r_ovld;

    assign adv        = !r_ovld || o_out.ready;
    assign i_in.ready = adv;

    logic signed [W-1:0] in_a [3];
    logic signed [W-1:0] in_b [3];
    logic signed [W-1:0] in_c [3];
    logic signed [W-1:0] in_q [3];

    assign in_a[0] = i_in.a_x;
    assign in_a[1] = i_in.a_y;
    assign in_a[2] = i_in.a_z;
    assign in_b[0] = i_in.b_x;
    assign in_b[1] = i_in.b_y;
    assign in_b[2] = i_in.b_z;
    assign in_c[0] = i_in.c_x;
    assign in_c[1] = i_in.c_y;
    assign in_c[2] = i_in.c_z;
    assign in_q[0] = i_in.query_x;
    assign in_q[1] = i_in.query_y;
    assign in_q[2] = i_in.query_z;

    // stage 1: edge vectors
    logic                 r_v1d, r_v2d, r_v3d, r_v4d, r_v5d, r_v6d;
    logic signed [W-1:0]  r1_a [3], r1_q [3];
    logic signed [VW-1:0] r1_v1 [3], r1_v2 [3];

    // stage 2: dot products
    logic signed [W-1:0]  r2_a [3], r2_q [3];
    logic signed [VW-1:0] r2_v1 [3], r2_v2 [3];
    logic signed [DW-1:0] r2_d11, r2_d12, r2_d22, r2_p1, r2_p2;
    logic signed [DW-1:0] n2_d11, n2_d12, n2_d22, n2_p1, n2_p2;

    // stage 3: products of dot products
    logic signed [W-1:0]    r3_a [3], r3_q [3];
    logic signed [VW-1:0]   r3_v1 [3], r3_v2 [3];
    logic signed [2*DW-1:0] r3_m11_22, r3_m12_12, r3_m2_12, r3_m1_22, r3_m1_12, r3_m2_11;

    // stage 4: determinant and numerators
    logic signed [W-1:0]  r4_a [3], r4_q [3];
    logic signed [VW-1:0] r4_v1 [3], r4_v2 [3];
    logic signed [LW-1:0] r4_det, r4_l1, r4_l2;

    // stage 5: weighted edges and flags
    logic signed [W-1:0]  r5_a [3], r5_q [3];
    logic signed [PW-1:0] r5_t1 [3], r5_t2 [3];
    logic signed [LW-1:0] r5_det;
    logic                 r5_ok, r5_inside;
    logic signed [LW:0]   n5_lsum;

    // stage 6: numerator magnitude and sign
    logic [SDW-1:0]       r6_sd;
    logic [NW-1:0]        r6_mag [3];
    logic                 r6_neg [3];
    logic [LW-2:0]        r6_den;
    logic signed [NW-1:0] n6_num [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1d <= 1'b0;
            r_v2d <= 1'b0;
            r_v3d <= 1'b0;
            r_v4d <= 1'b0;
            r_v5d <= 1'b0;
            r_v6d <= 1'b0;
        end else if (adv) begin
            r_v1d <= i_in.valid;
            r_v2d <= r_v1d;
            r_v3d <= r_v2d;
            r_v4d <= r_v3d;
            r_v5d <= r_v4d;
            r_v6d <= r_v5d;
        end
    end

    always_comb begin
        n2_d11 = '0;
        n2_d12 = '0;
        n2_d22 = '0;
        n2_p1  = '0;
        n2_p2  = '0;
        for (int k = 0; k < 3; k++) begin
            n2_d11 = n2_d11 + DW'(r1_v1[k]) * DW'(r1_v1[k]);
            n2_d12 = n2_d12 + DW'(r1_v1[k]) * DW'(r1_v2[k]);
            n2_d22 = n2_d22 + DW'(r1_v2[k]) * DW'(r1_v2[k]);
            n2_p1  = n2_p1 + DW'(r1_a[k]) * DW'(r1_v1[k]);
            n2_p2  = n2_p2 + DW'(r1_a[k]) * DW'(r1_v2[k]);
        end
        n5_lsum = (LW+1)'(r4_l1) + (LW+1)'(r4_l2);
        for (int k = 0; k < 3; k++) begin
            n6_num[k] = NW'(r5_t1[k]) + NW'(r5_t2[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r1_a[k]  <= in_a[k];
                r1_q[k]  <= in_q[k];
                r1_v1[k] <= VW'(in_b[k]) - VW'(in_a[k]);
                r1_v2[k] <= VW'(in_c[k]) - VW'(in_a[k]);

                r2_a[k]  <= r1_a[k];
                r2_q[k]  <= r1_q[k];
                r2_v1[k] <= r1_v1[k];
                r2_v2[k] <= r1_v2[k];

                r3_a[k]  <= r2_a[k];
                r3_q[k]  <= r2_q[k];
                r3_v1[k] <= r2_v1[k];
                r3_v2[k] <= r2_v2[k];

                r4_a[k]  <= r3_a[k];
                r4_q[k]  <= r3_q[k];
                r4_v1[k] <= r3_v1[k];
                r4_v2[k] <= r3_v2[k];

                r5_a[k]  <= r4_a[k];
                r5_q[k]  <= r4_q[k];
                r5_t1[k] <= PW'(r4_l1) * PW'(r4_v1[k]);
                r5_t2[k] <= PW'(r4_l2) * PW'(r4_v2[k]);

                r6_neg[k] <= n6_num[k][NW-1];
                r6_mag[k] <= n6_num[k][NW-1] ? NW'(-n6_num[k]) : NW'(n6_num[k]);
            end
            r2_d11 <= n2_d11;
            r2_d12 <= n2_d12;
            r2_d22 <= n2_d22;
            r2_p1  <= n2_p1;
            r2_p2  <= n2_p2;

            r3_m11_22 <= (2*DW)'(r2_d11) * (2*DW)'(r2_d22);
            r3_m12_12 <= (2*DW)'(r2_d12) * (2*DW)'(r2_d12);
            r3_m2_12  <= (2*DW)'(r2_p2) * (2*DW)'(r2_d12);
            r3_m1_22  <= (2*DW)'(r2_p1) * (2*DW)'(r2_d22);
            r3_m1_12  <= (2*DW)'(r2_p1) * (2*DW)'(r2_d12);
            r3_m2_11  <= (2*DW)'(r2_p2) * (2*DW)'(r2_d11);

            r4_det <= LW'(r3_m11_22) - LW'(r3_m12_12);
            r4_l1  <= LW'(r3_m2_12) - LW'(r3_m1_22);
            r4_l2  <= LW'(r3_m1_12) - LW'(r3_m2_11);

            r5_det    <= r4_det;
            r5_ok     <= r4_det > 0;
            r5_inside <= !r4_l1[LW-1] && !r4_l2[LW-1] && (n5_lsum <= (LW+1)'(r4_det));

            r6_den <= r5_det[LW-2:0];
            r6_sd  <= {r5_ok, r5_inside, r5_a[0], r5_a[1], r5_a[2],
                       r5_q[0], r5_q[1], r5_q[2]};
        end
    end

    // divider per axis, side data delayed alongside
    logic          dv_vld [3];
    logic [QB-1:0] dv_quo [3];
    logic          dv_ovf [3];
    logic          dv_neg [3];
    t_ctl          div_ctl;

    assign div_ctl.adv = adv;
    assign div_ctl.vld = r_v6d;

    for (genvar k = 0; k < 3; k++) begin : g_div
        tpco_div #(
            .NW   (NW),
            .DENW (LW - 1),
            .QB   (QB)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (div_ctl),
            .i_mag   (r6_mag[k]),
            .i_den   (r6_den),
            .i_neg   (r6_neg[k]),
            .o_vld   (dv_vld[k]),
            .o_quo   (dv_quo[k]),
            .o_ovf   (dv_ovf[k]),
            .o_neg   (dv_neg[k])
        );
    end

    logic [SDW-1:0] r_sd [QB+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd[0] <= r6_sd;
            for (int j = 1; j <= QB; j++) begin
                r_sd[j] <= r_sd[j-1];
            end
        end
    end

    logic                sd_ok, sd_inside;
    logic signed [W-1:0] sd_a [3], sd_q [3];

    assign {sd_ok, sd_inside, sd_a[0], sd_a[1], sd_a[2], sd_q[0], sd_q[1], sd_q[2]}
        = r_sd[QB];

    // stage 7: add base vertex and saturate
    logic                r_v7d, r_v8d, r_v9d;
    logic                r7_ok, r7_inside, r8_ok, r8_inside, r9_ok, r9_inside;
    logic signed [W-1:0] r7_near [3], r7_q [3], r8_near [3], r9_near [3];
    logic signed [W:0]   r8_lev [3];
    logic signed [W+2:0] n7_val [3], n7_qs [3];
    logic signed [W-1:0] n7_near [3];
    logic [SW-1:0]       r9_sq [3];
    logic signed [VSW-1:0] r9_lv [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n7_qs[k]  = $signed({2'b00, dv_quo[k]});
            n7_val[k] = (W+3)'(sd_a[k]) + (dv_neg[k] ? -n7_qs[k] : n7_qs[k]);
            priority if (dv_ovf[k]) begin
                n7_near[k] = dv_neg[k] ? LOW : HIW;
            end else if (n7_val[k] > HI3) begin
                n7_near[k] = HIW;
            end else if (n7_val[k] < LO3) begin
                n7_near[k] = LOW;
            end else begin
                n7_near[k] = n7_val[k][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7d <= 1'b0;
            r_v8d <= 1'b0;
            r_v9d <= 1'b0;
        end else if (adv) begin
            r_v7d <= dv_vld[0] & dv_vld[1] & dv_vld[2];
            r_v8d <= r_v7d;
            r_v9d <= r_v8d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r7_near[k] <= n7_near[k];
                r7_q[k]    <= sd_q[k];
                r8_near[k] <= r7_near[k];
                r8_lev[k]  <= (W+1)'(r7_q[k]) - (W+1)'(r7_near[k]);
                r9_near[k] <= r8_near[k];
                r9_sq[k]   <= SW'((2*W)'(r8_near[k]) * (2*W)'(r8_near[k]));
                r9_lv[k]   <= VSW'(r8_near[k]) * VSW'(r8_lev[k]);
            end
            r7_ok     <= sd_ok;
            r7_inside <= sd_inside;
            r8_ok     <= r7_ok;
            r8_inside <= r7_inside;
            r9_ok     <= r8_ok;
            r9_inside <= r8_inside;
        end
    end

    // output stage: sums, distance clamp, mask invalid results
    logic [XW-1:0]         n_dsum;
    logic signed [VSW-1:0] n_vsum;
    logic                  r_ok, r_inside, r_vis;
    logic signed [W-1:0]   r_near [3];
    logic [31:0]           r_dist;

    always_comb begin
        n_dsum = XW'(r9_sq[0]) + XW'(r9_sq[1]) + XW'(r9_sq[2]);
        n_vsum = r9_lv[0] + r9_lv[1] + r9_lv[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_ovld <= r_v9d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ok     <= r9_ok;
            r_inside <= r9_ok && r9_inside;
            r_vis    <= r9_ok && (n_vsum > 0);
            r_dist   <= !r9_ok ? 32'd0 :
                        (|n_dsum[XW-1:32]) ? 32'hFFFF_FFFF : n_dsum[31:0];
            for (int k = 0; k < 3; k++) begin
                r_near[k] <= r9_ok ? r9_near[k] : '0;
            end
        end
    end

    assign o_out.valid      = r_ovld;
    assign o_out.valid_res  = r_ok;
    assign o_out.near_x     = r_near[0];
    assign o_out.near_y     = r_near[1];
    assign o_out.near_z     = r_near[2];
    assign o_out.dist_sq    = r_dist;
    assign o_out.inside_res = r_inside;
    assign o_out.visible    = r_vis;

endmodule

### sim/tb_top.sv
// Self-checking bench for triangle_plane_closest_to_origin: random and directed triangles,
// predicted results compared per field in order. Depends on tpco_pkg, tpco_if and the DUT.
`timescale 1ns / 1ps

module tb_top;

    localparam int CB       = 16;
    localparam int LATENCY  = CB + 12;
    localparam int N_RANDOM = 1230;

    typedef struct packed {
        logic signed [CB-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, q_x, q_y, q_z;
    } t_triangle;

    typedef struct packed {
        logic                 valid_res;
        logic signed [CB-1:0] near_x, near_y, near_z;
        logic [31:0]          dist_sq;
        logic                 inside_res;
        logic                 visible;
    } t_near_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tpco_in_if  #(.COORD_BITS(CB)) in_if ();
    tpco_out_if #(.COORD_BITS(CB)) out_if ();

    triangle_plane_closest_to_origin #(.COORD_BITS(CB)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_triangle   pending_tris[$];
    t_near_point expected_pts[$];
    int          n_errors = 0;
    int          n_sent = 0;
    int          phase = 0;
    logic        in_took = 1'b0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    function automatic logic signed [127:0] sat_coord(logic signed [127:0] v);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (CB - 1)) - 128'sd1;
        lo = -hi - 128'sd1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_near_point predict_near_point(t_triangle t);
        logic signed [127:0] a[3], q[3], v1[3], v2[3], nb[3];
        logic signed [127:0] d11, d12, d22, p1, p2, det, l1, l2, num, sq_len, vis;
        t_near_point r;
        a[0] = t.a_x; a[1] = t.a_y; a[2] = t.a_z;
        q[0] = t.q_x; q[1] = t.q_y; q[2] = t.q_z;
        v1[0] = 128'(t.b_x) - a[0]; v1[1] = 128'(t.b_y) - a[1]; v1[2] = 128'(t.b_z) - a[2];
        v2[0] = 128'(t.c_x) - a[0]; v2[1] = 128'(t.c_y) - a[1]; v2[2] = 128'(t.c_z) - a[2];
        d11 = v1[0] * v1[0] + v1[1] * v1[1] + v1[2] * v1[2];
        d12 = v1[0] * v2[0] + v1[1] * v2[1] + v1[2] * v2[2];
        d22 = v2[0] * v2[0] + v2[1] * v2[1] + v2[2] * v2[2];
        p1  = a[0] * v1[0] + a[1] * v1[1] + a[2] * v1[2];
        p2  = a[0] * v2[0] + a[1] * v2[1] + a[2] * v2[2];
        det = d11 * d22 - d12 * d12;
        l1  = p2 * d12 - p1 * d22;
        l2  = p1 * d12 - p2 * d11;
        r = '0;
        if (det <= 0) return r;
        for (int k = 0; k < 3; k++) begin
            num   = l1 * v1[k] + l2 * v2[k];
            nb[k] = sat_coord(a[k] + num / det);
        end
        sq_len = nb[0] * nb[0] + nb[1] * nb[1] + nb[2] * nb[2];
        vis    = nb[0] * (q[0] - nb[0]) + nb[1] * (q[1] - nb[1]) + nb[2] * (q[2] - nb[2]);
        r.valid_res  = 1'b1;
        r.near_x     = nb[0][CB-1:0];
        r.near_y     = nb[1][CB-1:0];
        r.near_z     = nb[2][CB-1:0];
        r.dist_sq    = (sq_len > 128'sh0FFFF_FFFF) ? 32'hFFFF_FFFF : sq_len[31:0];
        r.inside_res = (l1 >= 0) && (l2 >= 0) && (l1 + l2 <= det);
        r.visible    = vis > 0;
        return r;
    endfunction

    function automatic logic signed [CB-1:0] rand_coord(int span);
        if (span == 0) return CB'($urandom);
        return CB'($urandom_range(2 * span - 1) - span);
    endfunction

    function automatic t_triangle make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz, int qx, int qy, int qz);
        t_triangle t;
        t.a_x = CB'(ax); t.a_y = CB'(ay); t.a_z = CB'(az);
        t.b_x = CB'(bx); t.b_y = CB'(by); t.b_z = CB'(bz);
        t.c_x = CB'(cx); t.c_y = CB'(cy); t.c_z = CB'(cz);
        t.q_x = CB'(qx); t.q_y = CB'(qy); t.q_z = CB'(qz);
        return t;
    endfunction

    function automatic t_triangle random_tri();
        t_triangle t;
        int mode;
        int span;
        mode = $urandom_range(9);
        span = (mode < 2) ? 0 : (mode < 5) ? 256 : 2048;
        t = {rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
             rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
             rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
        if (mode == 8) begin
            t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
        end else if (mode == 9) begin
            t.c_x = t.b_x + (t.b_x - t.a_x);
            t.c_y = t.b_y + (t.b_y - t.a_y);
            t.c_z = t.b_z + (t.b_z - t.a_z);
        end
        return t;
    endfunction

    // Driver: offer the next pending triangle at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_took) begin
            if (pending_tris.size() > 0 &&
                $urandom_range(99) >= ((phase == 0) ? 24 : (phase == 1) ? 57 : 0)) begin
                {in_if.a_x, in_if.a_y, in_if.a_z, in_if.b_x, in_if.b_y, in_if.b_z,
                 in_if.c_x, in_if.c_y, in_if.c_z, in_if.query_x, in_if.query_y,
                 in_if.query_z} <= pending_tris.pop_front();
                in_if.valid <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with one long hold-off to back the pipeline up.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (!hold_done && n_sent >= 200) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= $urandom_range(99) >= ((phase == 0) ? 57 : (phase == 1) ? 24 : 0);
        end
    end

    always @(posedge i_clk) begin
        in_took <= in_if.valid && in_if.ready && i_rst_n;
        if (in_if.valid && in_if.ready && i_rst_n) begin
            expected_pts.push_back(predict_near_point({in_if.a_x, in_if.a_y, in_if.a_z,
                in_if.b_x, in_if.b_y, in_if.b_z, in_if.c_x, in_if.c_y, in_if.c_z,
                in_if.query_x, in_if.query_y, in_if.query_z}));
            n_sent <= n_sent + 1;
            phase  <= (n_sent < 420) ? 0 : (n_sent < 840) ? 1 : 2;
        end
    end

    // Monitor: check each result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_near_point exp_pt;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_pts.size() == 0) begin
                $error("result transfer with nothing expected");
                n_errors++;
            end else begin
                exp_pt = expected_pts.pop_front();
                if (out_if.valid_res !== exp_pt.valid_res) begin
                    $error("valid_res exp %0d got %0d", exp_pt.valid_res, out_if.valid_res);
                    n_errors++;
                end
                if (out_if.near_x !== exp_pt.near_x) begin
                    $error("near_x exp %0d got %0d", exp_pt.near_x, out_if.near_x);
                    n_errors++;
                end
                if (out_if.near_y !== exp_pt.near_y) begin
                    $error("near_y exp %0d got %0d", exp_pt.near_y, out_if.near_y);
                    n_errors++;
                end
                if (out_if.near_z !== exp_pt.near_z) begin
                    $error("near_z exp %0d got %0d", exp_pt.near_z, out_if.near_z);
                    n_errors++;
                end
                if (out_if.dist_sq !== exp_pt.dist_sq) begin
                    $error("dist_sq exp %0h got %0h", exp_pt.dist_sq, out_if.dist_sq);
                    n_errors++;
                end
                if (out_if.inside_res !== exp_pt.inside_res) begin
                    $error("inside_res exp %0d got %0d", exp_pt.inside_res, out_if.inside_res);
                    n_errors++;
                end
                if (out_if.visible !== exp_pt.visible) begin
                    $error("visible exp %0d got %0d", exp_pt.visible, out_if.visible);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_tris.push_back(make_tri(256, 0, 256, 0, 256, 256, -256, -256, 256,
                                        0, 0, 1024));
        pending_tris.push_back(make_tri(256, 0, 256, 0, 256, 256, -256, -256, 256,
                                        0, 0, -1024));
        pending_tris.push_back(make_tri(1024, 0, 256, 2048, 0, 256, 1024, 512, 256,
                                        0, 0, 0));
        pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                        -32768, 32767, -32768, 32767, -32768, 32767));
        pending_tris.push_back(make_tri(32767, 32767, 32767, 32767, -32768, 32767,
                                        -32768, 32767, 32767, -32768, -32768, -32768));
        pending_tris.push_back(make_tri(32767, 0, 0, 32767, 1, 0, 32767, 0, 1,
                                        0, 0, 0));
        pending_tris.push_back(make_tri(-32768, 0, 0, -32768, 1, 0, -32768, 0, 1,
                                        32767, 32767, 32767));
        pending_tris.push_back(make_tri(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767,
                                        -1, -1, -1));
        pending_tris.push_back(make_tri(100, 100, 100, 100, 100, 100, 300, 0, 5,
                                        1, 2, 3));
        pending_tris.push_back(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9, 0, 0, 0));
        pending_tris.push_back(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5, 9, 9, 9));
        pending_tris.push_back(make_tri(-512, -512, 300, 512, -512, 300, 0, 512, 300,
                                        -32768, -32768, -32768));
        pending_tris.push_back(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 1, 1));
        pending_tris.push_back(make_tri(-1, -1, -1, -2, -1, -1, -1, -2, -1, 0, 0, 0));
        for (int i = 0; i < N_RANDOM; i++)
            pending_tris.push_back(random_tri());
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_tris.size() == 0 && !in_if.valid && expected_pts.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0 && expected_pts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### triangle_plane_closest_to_origin.f
design/tpco_pkg.sv
design/tpco_if.sv
design/tpco_div.sv
design/triangle_plane_closest_to_origin.sv
sim/tb_top.sv
